FILE: rtl/tmb_pkg.sv
// Shared constants, opcodes and helpers for the timer bank.
package tmb_pkg;

   localparam int NUM_TIMERS   = 16;
   localparam int IDX_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W        = $clog2(NUM_TIMERS + 1);
   localparam int SLOT_W       = 4;
   localparam int TIME_W       = 32;
   localparam int OP_W         = 3;
   localparam int RESULT_LIMIT = 16;
   localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);

   localparam logic [TIME_W-1:0] MAX_TIME_RESET = 32'd65535;

   localparam logic [OP_W-1:0] OP_CREATE        = 3'd0;
   localparam logic [OP_W-1:0] OP_START         = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP          = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_TIMEOUT   = 3'd3;
   localparam logic [OP_W-1:0] OP_RESTART_COUNT = 3'd4;
   localparam logic [OP_W-1:0] OP_TICK          = 3'd5;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [TIME_W-1:0] time_type;

   // Result slot field carries the low bits of a timer index.
   function automatic logic [SLOT_W-1:0] slot_of(input idx_type idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

endpackage

FILE: rtl/tmb_if.sv
// Valid/ready channel interfaces for requests, responses and the CSR write.
interface tmb_req_if;
   import tmb_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [SLOT_W-1:0]   timer_index;
   logic [TIME_W-1:0]   value;
   logic                periodic;
   logic [TIME_W-1:0]   now_time;
   modport source (output valid, opcode, timer_index, value, periodic, now_time,
                   input ready);
   modport sink   (input valid, opcode, timer_index, value, periodic, now_time,
                   output ready);
endinterface

interface tmb_rsp_if;
   import tmb_pkg::*;
   logic                valid;
   logic                ready;
   logic                status;
   logic [SLOT_W-1:0]   slot;
   logic                fired;
   logic                last;
   modport source (output valid, status, slot, fired, last, input ready);
   modport sink   (input valid, status, slot, fired, last, output ready);
endinterface

interface tmb_csr_if;
   import tmb_pkg::*;
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/tmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/oneshot_periodic_timer_bank_core.sv
// Timer bank top level: command decode, tick scan sequencer, shared add/sub unit.
// Commands other than tick: ST_OUT registers the result once rsp is free, then idles.
// Tick: ST_NEXT skips each stopped timer; a running one takes difference, wrap fix
//   (on borrow), compare and expiry (on a hit) steps through one 33-bit adder; ST_LAST closes.
// One item at a time; req ready only while the sequencer is idle; rsp stalls hold it.
// Synchronous active-high reset clears running flags and count, sets max_time to 65535.
module oneshot_periodic_timer_bank_core (
   input logic     clock,
   input logic     reset,
   tmb_req_if.sink   req_ch,
   tmb_rsp_if.source rsp_ch,
   tmb_csr_if.sink   csr_ch
);
   import tmb_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
   localparam logic [ST_W-1:0] ST_OUT  = 3'd1;
   localparam logic [ST_W-1:0] ST_NEXT = 3'd2;
   localparam logic [ST_W-1:0] ST_DIFF = 3'd3;
   localparam logic [ST_W-1:0] ST_WRAP = 3'd4;
   localparam logic [ST_W-1:0] ST_CMP  = 3'd5;
   localparam logic [ST_W-1:0] ST_FIRE = 3'd6;
   localparam logic [ST_W-1:0] ST_LAST = 3'd7;

   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // control
   logic [ST_W-1:0]       state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [NRES_W-1:0]     nres_ff, nres_in;
   logic                  held_ff, held_in;
   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   time_type              max_time_ff, max_time_in;

   // payload
   time_type              now_ff, now_in;
   time_type              acc_ff, acc_in;
   idx_type               held_slot_ff, held_slot_in;
   logic                  pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic                  out_status_ff, out_status_in;
   logic [SLOT_W-1:0]     out_slot_ff, out_slot_in;
   logic                  out_fired_ff, out_fired_in;
   logic                  out_last_ff, out_last_in;

   // memories
   logic     st_we, to_we, per_we, per_data, periodic_rd;
   idx_type  st_addr, to_addr, per_addr, scan_idx, cmd_idx, new_idx;
   time_type st_data, to_data, start_rd, timeout_rd;

   // shared adder
   time_type          alu_a, alu_b;
   logic              alu_sub;
   logic [TIME_W:0]   alu_sum;

   logic              req_fire, out_free, cmd_bad, bank_full, scan_done, fire_hit;
   logic [CMP_W-1:0]  cmd_ext, count_ext;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ext   = CMP_W'(req_ch.timer_index);
   assign count_ext = CMP_W'(count_ff);
   assign cmd_bad   = cmd_ext >= count_ext;
   assign cmd_idx   = cmd_ext[IDX_W-1:0];
   assign new_idx   = count_ff[IDX_W-1:0];
   assign bank_full = count_ff >= CNT_W'(NUM_TIMERS);
   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_done = scan_ff >= count_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.slot   = out_slot_ff;
   assign rsp_ch.fired  = out_fired_ff;
   assign rsp_ch.last   = out_last_ff;

   tmb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_addr),
      .wr_data (st_data),
      .rd_addr (scan_idx),
      .rd_data (start_rd)
   );

   tmb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_timeout_ram (
      .clock   (clock),
      .wr_en   (to_we),
      .wr_addr (to_addr),
      .wr_data (to_data),
      .rd_addr (scan_idx),
      .rd_data (timeout_rd)
   );

   tmb_ram #(.WIDTH(1), .DEPTH(NUM_TIMERS)) u_periodic_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (per_addr),
      .wr_data (per_data),
      .rd_addr (scan_idx),
      .rd_data (periodic_rd)
   );

   // a + b or a - b; carry out set means a >= b when subtracting
   always_comb begin
      unique case (state_ff)
         ST_DIFF: begin
            alu_a   = now_ff;
            alu_b   = start_rd;
            alu_sub = 1'b1;
         end
         ST_WRAP: begin
            alu_a   = acc_ff;
            alu_b   = max_time_ff;
            alu_sub = 1'b0;
         end
         default: begin
            alu_a   = acc_ff;
            alu_b   = timeout_rd;
            alu_sub = 1'b1;
         end
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {TIME_W{alu_sub}}}
                + (TIME_W + 1)'(alu_sub);
   end

   assign fire_hit = alu_sum[TIME_W];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      nres_in        = nres_ff;
      held_in        = held_ff;
      running_in     = running_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      max_time_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : max_time_ff;
      now_in         = now_ff;
      acc_in         = acc_ff;
      held_slot_in   = held_slot_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      out_status_in  = out_status_ff;
      out_slot_in    = out_slot_ff;
      out_fired_in   = out_fired_ff;
      out_last_in    = out_last_ff;
      st_we          = 1'b0;
      st_addr        = cmd_idx;
      st_data        = req_ch.now_time;
      to_we          = 1'b0;
      to_addr        = cmd_idx;
      to_data        = req_ch.value;
      per_we         = 1'b0;
      per_addr       = new_idx;
      per_data       = req_ch.periodic;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in       = ST_OUT;
               pend_status_in = 1'b0;
               pend_slot_in   = req_ch.timer_index;
               unique case (req_ch.opcode)
                  OP_CREATE: begin
                     if (bank_full) begin
                        pend_status_in = 1'b1;
                        pend_slot_in   = '0;
                     end else begin
                        st_we                = 1'b1;
                        st_addr              = new_idx;
                        to_we                = 1'b1;
                        to_addr              = new_idx;
                        per_we               = 1'b1;
                        running_in[new_idx]  = 1'b0;
                        count_in             = count_ff + 1'b1;
                        pend_slot_in         = slot_of(new_idx);
                     end
                  end
                  OP_START, OP_STOP, OP_SET_TIMEOUT, OP_RESTART_COUNT: begin
                     if (cmd_bad) begin
                        pend_status_in = 1'b1;
                     end else if (req_ch.opcode == OP_START) begin
                        st_we               = 1'b1;
                        running_in[cmd_idx] = 1'b1;
                     end else if (req_ch.opcode == OP_STOP) begin
                        running_in[cmd_idx] = 1'b0;
                     end else if (req_ch.opcode == OP_SET_TIMEOUT) begin
                        to_we = 1'b1;
                     end else begin
                        st_we = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_NEXT;
                     now_in   = req_ch.now_time;
                     scan_in  = '0;
                     nres_in  = '0;
                     held_in  = 1'b0;
                  end
                  default: begin
                     pend_status_in = 1'b1;
                     pend_slot_in   = '0;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = pend_status_ff;
               out_slot_in   = pend_slot_ff;
               out_fired_in  = 1'b0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_NEXT: begin
            if (scan_done) begin
               state_in = ST_LAST;
            end else if (running_ff[scan_idx]) begin
               state_in = ST_DIFF;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            // now - start; borrow means the clock wrapped, add max_time next
            acc_in   = alu_sum[TIME_W-1:0];
            state_in = alu_sum[TIME_W] ? ST_CMP : ST_WRAP;
         end
         ST_WRAP: begin
            acc_in   = alu_sum[TIME_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (fire_hit) begin
               if (periodic_rd) begin
                  st_we   = 1'b1;
                  st_addr = scan_idx;
                  st_data = now_ff;
               end else begin
                  running_in[scan_idx] = 1'b0;
               end
            end
            if (fire_hit && nres_ff != NRES_W'(RESULT_LIMIT)) begin
               state_in = ST_FIRE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_FIRE: begin
            // one expiry is held back until we know whether it is the last
            if (!held_ff || out_free) begin
               if (held_ff) begin
                  rsp_valid_in  = 1'b1;
                  out_status_in = 1'b0;
                  out_slot_in   = slot_of(held_slot_ff);
                  out_fired_in  = 1'b1;
                  out_last_in   = 1'b0;
               end
               held_in      = 1'b1;
               held_slot_in = scan_idx;
               nres_in      = nres_ff + 1'b1;
               scan_in      = scan_ff + 1'b1;
               state_in     = ST_NEXT;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = 1'b0;
               out_slot_in   = held_ff ? slot_of(held_slot_ff) : '0;
               out_fired_in  = held_ff;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         nres_ff      <= '0;
         held_ff      <= 1'b0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         max_time_ff  <= MAX_TIME_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         nres_ff      <= nres_in;
         held_ff      <= held_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         max_time_ff  <= max_time_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      acc_ff         <= acc_in;
      held_slot_ff   <= held_slot_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      out_status_ff  <= out_status_in;
      out_slot_ff    <= out_slot_in;
      out_fired_ff   <= out_fired_in;
      out_last_ff    <= out_last_in;
   end
endmodule

FILE: rtl/tmb_checker.sv
// Port-level checks on the timer bank, bound to the top level.
module tmb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_status,
   input logic [tmb_pkg::SLOT_W-1:0] rsp_slot,
   input logic                       rsp_fired,
   input logic                       rsp_last
);
   import tmb_pkg::*;

   // a waiting result stays valid and holds its slot and last flag until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_last))
      else $error("response dropped or changed while stalled");

   // one item at a time: an accepted item blocks the next one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item in flight");

   // only expiry reports may be followed by more results of the same item
   a_not_last_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_fired && !rsp_status)
      else $error("non-final response without expiry");

   // errors never report an expiry and end the item
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_fired && rsp_last)
      else $error("error response with expiry or not last");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind oneshot_periodic_timer_bank_core tmb_checker u_tmb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.slot),
   .rsp_fired  (rsp_ch.fired),
   .rsp_last   (rsp_ch.last)
);

FILE: tb/sv/oneshot_periodic_timer_bank_core_tb.sv
// Testbench for the timer bank core: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module oneshot_periodic_timer_bank_core_tb;
   import tmb_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] idx;
      time_type          val;
      logic              per;
      time_type          now;
   } timer_cmd_type;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot;
      logic              fired;
      logic              last;
   } timer_reply_type;

   logic clock;
   logic reset;

   tmb_req_if req_ch();
   tmb_rsp_if rsp_ch();
   tmb_csr_if csr_ch();

   oneshot_periodic_timer_bank_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted bank state
   time_type bank_start   [NUM_TIMERS];
   time_type bank_limit   [NUM_TIMERS];
   logic     bank_periodic[NUM_TIMERS];
   logic     bank_running [NUM_TIMERS];
   int       bank_count;
   time_type bank_max_time;

   timer_cmd_type   cmd_queue[$];
   timer_reply_type due_replies[$];
   timer_cmd_type   next_cmd;

   int  mismatches;
   int  stall_cycles;
   int  csr_writes;
   logic req_took;
   logic rsp_took;
   logic csr_took;

   // traffic shaping
   logic req_idle_on;
   logic rsp_idle_on;
   int   req_gap;
   int   rsp_gap;
   int   hold_asked;
   int   hold_done;
   int   hold_left;

   // stimulus-side view of time and allocation
   time_type sys_now;
   int       gen_alloc;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic void push_reply(input logic st, input logic [SLOT_W-1:0] sl,
                                      input logic fi, input logic la);
      timer_reply_type r;
      r.status = st;
      r.slot   = sl;
      r.fired  = fi;
      r.last   = la;
      due_replies.push_back(r);
   endfunction

   // Apply one accepted command to the predicted bank and queue its replies.
   function automatic void step_timer_bank(input timer_cmd_type c);
      time_type elapsed;
      int       hits[$];
      if (c.op == OP_CREATE) begin
         if (bank_count >= NUM_TIMERS) begin
            push_reply(1'b1, '0, 1'b0, 1'b1);
         end else begin
            bank_running[bank_count]  = 1'b0;
            bank_periodic[bank_count] = c.per;
            bank_start[bank_count]    = c.now;
            bank_limit[bank_count]    = c.val;
            push_reply(1'b0, SLOT_W'(bank_count), 1'b0, 1'b1);
            bank_count++;
         end
      end else if (c.op == OP_START || c.op == OP_STOP || c.op == OP_SET_TIMEOUT ||
                   c.op == OP_RESTART_COUNT) begin
         if (int'(c.idx) >= bank_count) begin
            push_reply(1'b1, c.idx, 1'b0, 1'b1);
         end else begin
            case (c.op)
               OP_START: begin
                  bank_start[c.idx]   = c.now;
                  bank_running[c.idx] = 1'b1;
               end
               OP_STOP:        bank_running[c.idx] = 1'b0;
               OP_SET_TIMEOUT: bank_limit[c.idx] = c.val;
               default:        bank_start[c.idx] = c.now;
            endcase
            push_reply(1'b0, c.idx, 1'b0, 1'b1);
         end
      end else if (c.op == OP_TICK) begin
         for (int i = 0; i < bank_count; i++) begin
            if (bank_running[i]) begin
               // clock wrap uses max - start + now, not a modular difference
               if (c.now >= bank_start[i])
                  elapsed = c.now - bank_start[i];
               else
                  elapsed = bank_max_time - bank_start[i] + c.now;
               if (elapsed >= bank_limit[i]) begin
                  if (bank_periodic[i])
                     bank_start[i] = c.now;
                  else
                     bank_running[i] = 1'b0;
                  if (hits.size() < RESULT_LIMIT)
                     hits.push_back(i);
               end
            end
         end
         if (hits.size() == 0) begin
            push_reply(1'b0, '0, 1'b0, 1'b1);
         end else begin
            foreach (hits[k])
               push_reply(1'b0, SLOT_W'(hits[k]), 1'b1, k == hits.size() - 1);
         end
      end else begin
         push_reply(1'b1, '0, 1'b0, 1'b1);
      end
   endfunction

   function automatic void queue_cmd(input logic [OP_W-1:0] op, input int idx,
                                     input time_type val, input logic per,
                                     input time_type now);
      timer_cmd_type c;
      c.op  = op;
      c.idx = SLOT_W'(idx);
      c.val = val;
      c.per = per;
      c.now = now;
      cmd_queue.push_back(c);
   endfunction

   // Mostly sane traffic: time creeps forward and wraps at max_time, commands
   // aim at allocated slots. A few items carry arbitrary fields.
   function automatic void queue_random_cmds(input int count);
      timer_cmd_type c;
      int         r;
      int         cw;
      longint     nxt;
      for (int k = 0; k < count; k++) begin
         nxt     = (longint'(sys_now) + $urandom_range(0, 12)) % (longint'(bank_max_time) + 1);
         sys_now = time_type'(nxt);
         c.now   = sys_now;
         c.per   = 1'($urandom_range(0, 1));
         c.val   = ($urandom_range(0, 9) == 0) ? time_type'($urandom) :
                   time_type'($urandom_range(0, 40));
         if (gen_alloc > 0 && $urandom_range(0, 9) < 8)
            c.idx = SLOT_W'($urandom_range(0, gen_alloc - 1));
         else
            c.idx = SLOT_W'($urandom_range(0, 15));
         r  = $urandom_range(0, 99);
         cw = (gen_alloc < NUM_TIMERS) ? 18 : 3;
         if (r < 5) begin
            c.op  = OP_W'($urandom_range(0, 5));
            c.val = $urandom;
            c.now = $urandom;
         end else if (r < 5 + cw)
            c.op = OP_CREATE;
         else if (r < 25 + cw)
            c.op = OP_START;
         else if (r < 33 + cw)
            c.op = OP_STOP;
         else if (r < 41 + cw)
            c.op = OP_SET_TIMEOUT;
         else if (r < 49 + cw)
            c.op = OP_RESTART_COUNT;
         else
            c.op = OP_TICK;
         if (c.op == OP_CREATE && gen_alloc < NUM_TIMERS)
            gen_alloc++;
         cmd_queue.push_back(c);
      end
   endfunction

   task automatic write_max_time(input time_type data);
      int seen;
      seen = csr_writes;
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= data;
      do
         @(negedge clock);
      while (csr_writes == seen);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_bank();
      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || req_ch.valid || due_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_ch.valid || req_took) begin
         if (req_took && req_idle_on && $urandom_range(0, 3) == 0)
            req_gap = $urandom_range(1, 3);
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            next_cmd = cmd_queue.pop_front();
            req_ch.opcode      <= next_cmd.op;
            req_ch.timer_index <= next_cmd.idx;
            req_ch.value       <= next_cmd.val;
            req_ch.periodic    <= next_cmd.per;
            req_ch.now_time    <= next_cmd.now;
            req_ch.valid       <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver, with the occasional long hold-off
   always @(negedge clock) begin
      if (hold_asked != hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = hold_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_idle_on && $urandom_range(0, 5) == 0)
            rsp_gap = $urandom_range(1, 3);
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: predicts on accepted commands, checks accepted results
   always @(posedge clock) begin
      req_took = 1'b0;
      rsp_took = 1'b0;
      csr_took = 1'b0;
      if (!reset) begin
         req_took = req_ch.valid && req_ch.ready;
         rsp_took = rsp_ch.valid && rsp_ch.ready;
         csr_took = csr_ch.valid && csr_ch.ready;
         if (csr_took) begin
            bank_max_time = csr_ch.data;
            csr_writes++;
         end
         if (rsp_took) begin
            if (due_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected item status=%0d slot=%0d fired=%0d last=%0d",
                           $realtime, rsp_ch.status, rsp_ch.slot, rsp_ch.fired, rsp_ch.last);
            end else begin
               if (rsp_ch.status !== due_replies[0].status ||
                   rsp_ch.slot   !== due_replies[0].slot   ||
                   rsp_ch.fired  !== due_replies[0].fired  ||
                   rsp_ch.last   !== due_replies[0].last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $write("%0t: mismatch exp status=%0d slot=%0d fired=%0d last=%0d",
                            $realtime, due_replies[0].status, due_replies[0].slot,
                            due_replies[0].fired, due_replies[0].last);
                     $display(", got status=%0d slot=%0d fired=%0d last=%0d",
                              rsp_ch.status, rsp_ch.slot, rsp_ch.fired, rsp_ch.last);
                  end
               end
               void'(due_replies.pop_front());
            end
         end
         if (req_took) begin
            next_cmd.op  = req_ch.opcode;
            next_cmd.idx = req_ch.timer_index;
            next_cmd.val = req_ch.value;
            next_cmd.per = req_ch.periodic;
            next_cmd.now = req_ch.now_time;
            step_timer_bank(next_cmd);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || req_took || rsp_took || csr_took)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_TICK;
      req_ch.timer_index = '0;
      req_ch.value       = '0;
      req_ch.periodic    = 1'b0;
      req_ch.now_time    = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      bank_count    = 0;
      bank_max_time = MAX_TIME_RESET;
      foreach (bank_running[i])
         bank_running[i] = 1'b0;
      mismatches   = 0;
      stall_cycles = 0;
      csr_writes   = 0;
      req_took = 1'b0;
      rsp_took = 1'b0;
      csr_took = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      hold_asked = 0;
      hold_done  = 0;
      hold_left  = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      gen_alloc = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: errors on an empty bank, extremes of timeout and time, wrap
      queue_cmd(OP_START, 15, 0, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0, 0);
      queue_cmd(OP_CREATE, 9, 0, 1, 100);
      queue_cmd(OP_CREATE, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      queue_cmd(OP_STOP, 1, 0, 0, 0);
      queue_cmd(OP_START, 0, 0, 0, 100);
      queue_cmd(OP_START, 1, 0, 0, 200);
      queue_cmd(OP_TICK, 0, 0, 0, 200);
      queue_cmd(OP_CREATE, 6, 10, 0, 300);
      queue_cmd(OP_START, 2, 0, 0, 60000);
      queue_cmd(OP_TICK, 0, 0, 0, 5);
      queue_cmd(OP_SET_TIMEOUT, 0, 32'hFFFF_FFFF, 1, 0);
      queue_cmd(OP_RESTART_COUNT, 1, 0, 0, 32'hFFFF_FFFF);
      queue_cmd(OP_SET_TIMEOUT, 1, 0, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF);
      queue_cmd(OP_STOP, 0, 0, 0, 0);
      queue_cmd(OP_STOP, 3, 0, 0, 0);
      queue_cmd(OP_SET_TIMEOUT, 2, 5, 0, 0);
      queue_cmd(OP_RESTART_COUNT, 2, 0, 0, 7);
      queue_cmd(OP_RESTART_COUNT, 12, 0, 0, 7);
      queue_cmd(OP_TICK, 0, 0, 0, 0);
      gen_alloc = 3;
      drain_bank();

      // widest clock, starting just below the wrap; receiver stalls long once
      write_max_time(32'hFFFF_FFFF);
      sys_now = 32'hFFFF_FFFF - 300;
      queue_random_cmds(80);
      while (gen_alloc <= NUM_TIMERS) begin
         queue_cmd(OP_CREATE, $urandom_range(0, 15), $urandom_range(0, 40),
                   1'($urandom_range(0, 1)), sys_now);
         gen_alloc++;
      end
      hold_asked++;
      drain_bank();

      // narrowest clock
      rsp_idle_on = 1'b0;
      write_max_time(1);
      sys_now = 0;
      queue_random_cmds(60);
      drain_bank();

      req_idle_on = 1'($urandom_range(0, 1));
      rsp_idle_on = 1'b1;
      write_max_time($urandom_range(100, 100000));
      sys_now = $urandom_range(0, 99);
      queue_random_cmds(80);
      drain_bank();

      // back to the reset value, full rate on both sides
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_max_time(MAX_TIME_RESET);
      sys_now = 65000;
      queue_random_cmds(80);
      drain_bank();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_replies.size() != 0) begin
         $display("%0d expected items never arrived", due_replies.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
